// ----- hw/rtl/swr_pkg.sv -----
// ----------------------------------------------------------------------------
// swr_pkg
// Shared constants and controller/datapath interface types for the
// sample-without-replacement core.
// ----------------------------------------------------------------------------
package swr_pkg;

  // Fixed field widths
  localparam int RAND_W  = 32;
  localparam int START_W = 16;
  localparam int COUNT_W = 9;
  localparam int VALUE_W = 17;
  localparam int INDEX_W = 2;

  // Input commands
  localparam logic CMD_REFILL = 1'b0;
  localparam logic CMD_DRAW   = 1'b1;

  // Configuration register indexes
  localparam logic [INDEX_W-1:0] REG_START_VALUE = 2'd0;
  localparam logic [INDEX_W-1:0] REG_POOL_SIZE   = 2'd1;
  localparam logic [INDEX_W-1:0] REG_DRAW_COUNT  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [START_W-1:0] START_VALUE_RST = 16'd1;
  localparam logic [COUNT_W-1:0] POOL_SIZE_RST   = 9'd256;
  localparam logic [COUNT_W-1:0] DRAW_COUNT_RST  = 9'd1;

  // Controller -> datapath commands
  typedef struct packed {
    logic take_item;    // capture the accepted input transaction
    logic fill_start;   // clear sweep index, size the refill
    logic fill_step;    // write one pool entry with its own index
    logic fill_commit;  // reload counters, result is all zeros
    logic set_error;    // refused draw, result flags an error
    logic div_start;    // start random_word mod remaining
    logic pick;         // read picked entry, first shift read
    logic shift_step;   // move one entry down by one place
    logic draw_commit;  // count the draw
    logic emit;         // load the output register
  } swr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic is_draw;
    logic refused;
    logic fill_done;
    logic div_done;
    logic shift_more;
  } swr_status_t;

endpackage

// ----- hw/rtl/swr_divider.sv -----
// ----------------------------------------------------------------------------
// swr_divider
// Restoring remainder unit: one dividend bit per cycle, over all RAND_W dividend bits.
// ----------------------------------------------------------------------------
module swr_divider import swr_pkg::*; #(
  parameter int VW = 9
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [VW-1:0]     divisor,
  output logic              done,
  output logic [VW-1:0]     remainder
);

  localparam int CNT_W = $clog2(RAND_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [RAND_W-1:0] quo_shift;
  logic [VW-1:0]     rem;
  logic [VW:0]       trial;
  logic [VW:0]       trial_sub;
  logic              done_q;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial     = {rem, quo_shift[RAND_W-1]};
    trial_sub = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(RAND_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      quo_shift <= dividend;
      rem       <= '0;
    end else if (cnt != '0) begin
      quo_shift <= {quo_shift[RAND_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem <= trial_sub[VW-1:0];
      end else begin
        rem <= trial[VW-1:0];
      end
    end
  end

  assign done      = done_q;
  assign remainder = rem;

endmodule

// ----- hw/rtl/swr_datapath.sv -----
// ----------------------------------------------------------------------------
// swr_datapath
// Pool memory, counters, configuration registers and result registers.
// ----------------------------------------------------------------------------
module swr_datapath import swr_pkg::*; #(
  parameter int POOL_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  swr_cmd_t           ctl,
  output swr_status_t        sts,
  input  logic               in_cmd,
  input  logic [RAND_W-1:0]  in_random,
  input  logic               cfg_we,
  input  logic [INDEX_W-1:0] cfg_idx,
  input  logic [START_W-1:0] cfg_wdata,
  output logic [VALUE_W-1:0] drawn_value,
  output logic               draw_error,
  output logic               last_draw
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = $clog2(POOL_DEPTH + 1);

  // configuration
  logic [START_W-1:0] start_value;
  logic [COUNT_W-1:0] pool_size;
  logic [COUNT_W-1:0] draw_count;

  // control state
  logic [CW-1:0]      remaining;
  logic [COUNT_W-1:0] draws_done;

  // working registers
  logic               cmd_q;
  logic [RAND_W-1:0]  rnd_q;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      fill_n;
  logic [CW-1:0]      fill_size;
  logic [VALUE_W-1:0] res_value;
  logic               res_err;
  logic               res_last;
  logic [COUNT_W-1:0] draws_inc;
  logic               pick_q;
  logic [VALUE_W-1:0] pick_value;
  logic [AW-1:0]      pick_offset;

  // pool memory
  logic [AW-1:0] pool_mem [POOL_DEPTH];
  logic [AW-1:0] mem_rdata;
  logic [AW-1:0] mem_raddr;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_wdata;
  logic          mem_we;

  logic          div_done;
  logic [CW-1:0] div_rem;

  swr_divider #(
    .VW(CW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (rnd_q),
    .divisor   (remaining),
    .done      (div_done),
    .remainder (div_rem)
  );

  // refill size saturates at the pool depth
  always_comb begin
    if (32'(pool_size) > POOL_DEPTH) begin
      fill_size = CW'(POOL_DEPTH);
    end else begin
      fill_size = CW'(pool_size);
    end
  end

  assign draws_inc = draws_done + COUNT_W'(1);

  // memory port selection: picked entry, then the entry above it, then the
  // entry two above the one being written during the shift
  always_comb begin
    mem_we    = ctl.fill_step | ctl.shift_step;
    mem_waddr = idx[AW-1:0];
    mem_wdata = ctl.fill_step ? idx[AW-1:0] : mem_rdata;
    if (ctl.pick) begin
      mem_raddr = AW'(div_rem);
    end else if (pick_q) begin
      mem_raddr = AW'(idx + CW'(1));
    end else begin
      mem_raddr = AW'(idx + CW'(2));
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      pool_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= pool_mem[mem_raddr];
  end

  // configuration registers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value <= START_VALUE_RST;
      pool_size   <= POOL_SIZE_RST;
      draw_count  <= DRAW_COUNT_RST;
      remaining   <= '0;
      draws_done  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_START_VALUE: start_value <= cfg_wdata;
          REG_POOL_SIZE:   pool_size   <= cfg_wdata[COUNT_W-1:0];
          REG_DRAW_COUNT:  draw_count  <= cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (ctl.fill_commit) begin
        remaining  <= fill_n;
        draws_done <= '0;
      end else if (ctl.draw_commit) begin
        remaining  <= remaining - CW'(1);
        draws_done <= draws_inc;
      end
    end
  end

  // transaction capture, sweep index and result
  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      cmd_q <= in_cmd;
      rnd_q <= in_random;
    end
    if (ctl.fill_start) begin
      idx    <= '0;
      fill_n <= fill_size;
    end else if (ctl.fill_step || ctl.shift_step) begin
      idx <= idx + CW'(1);
    end else if (ctl.pick) begin
      idx <= div_rem;
    end
    if (ctl.fill_commit) begin
      res_value <= '0;
      res_err   <= 1'b0;
      res_last  <= 1'b0;
    end else if (ctl.set_error) begin
      res_value <= '0;
      res_err   <= 1'b1;
      res_last  <= 1'b0;
    end else if (ctl.draw_commit) begin
      res_value <= pick_value;
      res_err   <= 1'b0;
      res_last  <= (draws_inc == draw_count);
    end
    if (ctl.emit) begin
      drawn_value <= res_value;
      draw_error  <= res_err;
      last_draw   <= res_last;
    end
  end

  // value of the picked entry, read back the cycle after pick
  always_ff @(posedge clk) begin
    if (rst) begin
      pick_q <= 1'b0;
    end else begin
      pick_q <= ctl.pick;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pick) begin
      pick_offset <= '0;
    end else if (pick_q) begin
      pick_offset <= mem_rdata;
    end
  end

  assign pick_value = {1'b0, start_value} + VALUE_W'(pick_offset);

  // status to the controller
  always_comb begin
    sts.is_draw    = (cmd_q == CMD_DRAW);
    sts.refused    = (remaining == '0) || (draws_done >= draw_count);
    sts.fill_done  = (idx == fill_n);
    sts.div_done   = div_done;
    sts.shift_more = ({1'b0, idx} + (CW + 1)'(1)) < {1'b0, remaining};
  end

endmodule

// ----- hw/rtl/swr_ctrl.sv -----
// ----------------------------------------------------------------------------
// swr_ctrl
// Sequencer for refill sweeps and draws; owns the handshake flags.
// ----------------------------------------------------------------------------
module swr_ctrl import swr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  swr_status_t sts,
  output swr_cmd_t    ctl
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_FILL,
    S_DIVIDE,
    S_PICK,
    S_SHIFT,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // next state and command decode
  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.take_item = 1'b1;
          state_next    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts.is_draw) begin
          ctl.fill_start = 1'b1;
          state_next     = S_FILL;
        end else if (sts.refused) begin
          ctl.set_error = 1'b1;
          state_next    = S_EMIT;
        end else begin
          ctl.div_start = 1'b1;
          state_next    = S_DIVIDE;
        end
      end
      S_FILL: begin
        if (sts.fill_done) begin
          ctl.fill_commit = 1'b1;
          state_next      = S_EMIT;
        end else begin
          ctl.fill_step = 1'b1;
        end
      end
      S_DIVIDE: begin
        if (sts.div_done) begin
          ctl.pick   = 1'b1;
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        state_next = S_SHIFT;
      end
      S_SHIFT: begin
        if (sts.shift_more) begin
          ctl.shift_step = 1'b1;
        end else begin
          ctl.draw_commit = 1'b1;
          state_next      = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ctl.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/sample_without_replacement_core.sv -----
// ----------------------------------------------------------------------------
// sample_without_replacement_core
// Draws distinct values from start_value .. start_value+min(pool_size, POOL_DEPTH)-1.
//
//   channel  handshake             payload
//   in       in_valid / in_stall   cmd, random_word
//   out      out_valid / out_stall drawn_value, draw_error, last_draw
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// With a free output, a draw runs the bit-serial remainder, then shifts each
// pool entry above the picked one down by one place through the one read and
// one write port of the pool memory. A refill writes the pool entries, one
// memory write per cycle. Refused draws go straight to the output register.
// Reset empties the pool; pool memory contents are not cleared.
// A stalled output holds its result; the next transaction can be worked on
// meanwhile and waits only to load the output register.
// ----------------------------------------------------------------------------
module sample_without_replacement_core import swr_pkg::*; #(
  parameter int POOL_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [RAND_W-1:0]  random_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [VALUE_W-1:0] drawn_value,
  output logic               draw_error,
  output logic               last_draw,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [INDEX_W-1:0] cfg_index,
  input  logic [START_W-1:0] cfg_data
);

  swr_cmd_t    ctl;
  swr_status_t sts;

  // registers accept writes at any time
  assign cfg_ready = 1'b1;

  swr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  swr_datapath #(
    .POOL_DEPTH(POOL_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .in_cmd      (cmd),
    .in_random   (random_word),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_idx     (cfg_index),
    .cfg_wdata   (cfg_data),
    .drawn_value (drawn_value),
    .draw_error  (draw_error),
    .last_draw   (last_draw)
  );

endmodule
